// File: rtl/bsrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_pkg
// Opcodes, sizes and the record that travels from decode to execute.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    localparam int NUM_REGS_DEF    = 8;
    localparam int MEM_WORDS_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] OP_PUSH      = 8'h01;
    localparam logic [7:0] OP_MOV       = 8'h02;
    localparam logic [7:0] OP_ADDR      = 8'h03;
    localparam logic [7:0] OP_RESERVED  = 8'h04;
    localparam logic [7:0] OP_REG_PUSH  = 8'h05;
    localparam logic [7:0] OP_POP_REG   = 8'h06;
    localparam logic [7:0] OP_SHOW_TOP  = 8'h07;
    localparam logic [7:0] OP_SHOW_REG  = 8'h08;
    localparam logic [7:0] OP_CMP       = 8'h09;
    localparam logic [7:0] OP_JEQ       = 8'h0A;
    localparam logic [7:0] OP_JNE       = 8'h0B;
    localparam logic [7:0] OP_JGT       = 8'h0C;
    localparam logic [7:0] OP_JLT       = 8'h0D;
    localparam logic [7:0] OP_MEM_PUSH  = 8'h0E;
    localparam logic [7:0] OP_POP_MEM   = 8'h0F;
    localparam logic [7:0] OP_MEM_TO_REG = 8'h10;
    localparam logic [7:0] OP_REG_TO_MEM = 8'h11;
    localparam logic [7:0] OP_DECR      = 8'h12;
    localparam logic [7:0] OP_SHOW_CNT  = 8'h13;
    localparam logic [7:0] OP_STOP      = 8'h14;

    localparam logic [7:0] COUNTER_SEL = 8'hFF;

    localparam logic [1:0] PK_NONE  = 2'd0;
    localparam logic [1:0] PK_STACK = 2'd1;
    localparam logic [1:0] PK_REG   = 2'd2;
    localparam logic [1:0] PK_CNT   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       known;
    } t_instr;

endpackage

// File: rtl/bytecode_stack_register_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bytecode_stack_register_core
// Bytecode executor with a decode queue in front of a pipelined back end.
// ----------------------------------------------------------------------------
// One instruction is accepted per cycle while the queue has room, and each
// produces exactly one result: it passes the queue, then an operand stage that
// reads the data memory, then the execute register. Back-to-back instructions
// run at one per cycle while no result is held; the execute stage reads and
// updates registers and stack as it fires. A held result stalls the back end
// and, once the two-entry queue is full, the input. Write program_length only
// while no instruction is in flight.
module bytecode_stack_register_core #(
    parameter int NUM_REGS    = bsrc_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS   = bsrc_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = bsrc_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_operand_a,
    input  logic [7:0]  i_operand_b,
    input  logic [7:0]  i_operand_c,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [8:0]  o_next_pc,
    output logic        o_halted,
    output logic [1:0]  o_print_kind,
    output logic [2:0]  o_print_reg,
    output logic signed [31:0] o_print_value,
    output logic [1:0]  o_status
);
    logic [8:0] r_prog_len;
    logic q_valid, q_ready;
    bsrc_pkg::t_instr q_instr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (i_cfg_valid) begin
            r_prog_len <= i_cfg_data;
        end
    end

    bsrc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .i_operand_c(i_operand_c),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_instr(q_instr)
    );

    bsrc_back #(
        .NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prog_len(r_prog_len),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_instr(q_instr),
        .o_valid(o_valid), .i_ready(i_ready), .o_next_pc(o_next_pc),
        .o_halted(o_halted), .o_print_kind(o_print_kind),
        .o_print_reg(o_print_reg), .o_print_value(o_print_value),
        .o_status(o_status)
    );
endmodule

// File: rtl/bsrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_front
// Accepts instructions, classifies the opcode and queues them for execute.
// ----------------------------------------------------------------------------
module bsrc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_opcode,
    input  logic [7:0]        i_operand_a,
    input  logic [7:0]        i_operand_b,
    input  logic [7:0]        i_operand_c,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output bsrc_pkg::t_instr  o_q_instr
);
    localparam int QD = bsrc_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(QD);

    bsrc_pkg::t_instr r_q [QD];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;
    logic known;

    always_comb begin
        known = (i_opcode >= bsrc_pkg::OP_PUSH) && (i_opcode <= bsrc_pkg::OP_STOP)
                && (i_opcode != bsrc_pkg::OP_RESERVED);
    end

    assign o_ready   = (r_cnt != (AW+1)'(QD));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_instr = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_opcode, a: i_operand_a, b: i_operand_b,
                           c: i_operand_c, known: known};
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QD)) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(QD)) |-> !o_ready) else $error("full queue ready");
endmodule

// File: rtl/bsrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_back
// Executes one instruction per unstalled cycle on registers, stack and memory.
// ----------------------------------------------------------------------------
module bsrc_back #(
    parameter int NUM_REGS    = bsrc_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS   = bsrc_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = bsrc_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [8:0]        i_prog_len,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  bsrc_pkg::t_instr  i_q_instr,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [8:0]        o_next_pc,
    output logic              o_halted,
    output logic [1:0]        o_print_kind,
    output logic [2:0]        o_print_reg,
    output logic signed [31:0] o_print_value,
    output logic [1:0]        o_status
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int MW = $clog2(MEM_WORDS);
    localparam int RW = $clog2(NUM_REGS);

    // Register file and stack are flops. The data memory is read as an
    // instruction enters the operand stage, before it executes; valid bits
    // make unwritten words read as zero after reset.
    logic [31:0] r_regs  [NUM_REGS];
    logic [31:0] r_stack [STACK_DEPTH];
    logic [31:0] r_mem   [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_mem_vld;
    logic [CW-1:0] r_sp;
    logic [31:0]   r_lc;
    logic r_eq, r_gt, r_lt, r_halt;
    logic [8:0] r_pc;

    logic             r_s_valid;
    bsrc_pkg::t_instr r_s_instr;
    logic [31:0]      r_ma_raw, r_mb_raw, r_fwd_wd;
    logic             r_ma_ok, r_mb_ok, r_ma_fwd, r_mb_fwd;

    logic fire, q_take, mem_wr;
    logic [MW-1:0] qa, qb;
    logic [7:0] op, a, b, c;
    logic a_reg, b_reg, c_reg, a_mem, b_mem, full, nonempty;
    logic [31:0] ra, rb, rc, ma, mb, top, cx, cy;
    logic [9:0]  next;
    logic [1:0]  kind, st;
    logic [2:0]  preg;
    logic [31:0] pval;
    logic        halt_now, cease;
    logic        reg_we, mem_we, push_do, pop_do, flags_we, dec_do;
    logic [RW-1:0] reg_wa;
    logic [MW-1:0] mem_wa;
    logic [31:0] reg_wd, mem_wd, push_wd;

    assign fire      = r_s_valid && (!o_valid || i_ready);
    assign o_q_ready = !r_s_valid || fire;
    assign q_take    = i_q_valid && o_q_ready;
    assign qa = i_q_instr.a[MW-1:0];
    assign qb = i_q_instr.b[MW-1:0];
    assign op = r_s_instr.op;
    assign a  = r_s_instr.a;
    assign b  = r_s_instr.b;
    assign c  = r_s_instr.c;
    assign mem_wr = fire && !halt_now && mem_we;

    always_comb begin
        a_reg = 32'(a) < NUM_REGS;
        b_reg = 32'(b) < NUM_REGS;
        c_reg = 32'(c) < NUM_REGS;
        a_mem = 32'(a) < MEM_WORDS;
        b_mem = 32'(b) < MEM_WORDS;
        full  = 32'(r_sp) >= STACK_DEPTH;
        nonempty = r_sp != '0;
        ra = a_reg ? r_regs[a[RW-1:0]] : '0;
        rb = b_reg ? r_regs[b[RW-1:0]] : '0;
        rc = c_reg ? r_regs[c[RW-1:0]] : '0;
        ma = a_mem ? (r_ma_fwd ? r_fwd_wd : (r_ma_ok ? r_ma_raw : '0)) : '0;
        mb = b_mem ? (r_mb_fwd ? r_fwd_wd : (r_mb_ok ? r_mb_raw : '0)) : '0;
        top = nonempty ? r_stack[SW'(r_sp - 1'b1)] : '0;
        cx = (a == bsrc_pkg::COUNTER_SEL) ? r_lc : ra;
        cy = (b == bsrc_pkg::COUNTER_SEL) ? r_lc : rb;
    end

    always_comb begin
        next = {1'b0, r_pc} + 10'd1;
        kind = bsrc_pkg::PK_NONE; st = bsrc_pkg::ST_OK; preg = '0; pval = '0;
        cease = 1'b0; reg_we = 1'b0; mem_we = 1'b0; push_do = 1'b0;
        pop_do = 1'b0; flags_we = 1'b0; dec_do = 1'b0;
        reg_wa = a[RW-1:0]; mem_wa = a[MW-1:0];
        reg_wd = '0; mem_wd = '0; push_wd = '0;
        if (!r_s_instr.known) begin
            st = bsrc_pkg::ST_UNKNOWN;
        end else begin
            unique case (op)
                bsrc_pkg::OP_PUSH: begin
                    push_do = 1'b1; push_wd = {24'd0, a};
                end
                bsrc_pkg::OP_MOV: begin
                    reg_we = a_reg; reg_wd = {24'd0, b};
                end
                bsrc_pkg::OP_ADDR: begin
                    reg_we = a_reg && b_reg && c_reg; reg_wd = rb + rc;
                end
                bsrc_pkg::OP_REG_PUSH: begin
                    push_do = a_reg; push_wd = ra;
                end
                bsrc_pkg::OP_POP_REG: begin
                    pop_do = nonempty && a_reg; reg_we = pop_do; reg_wd = top;
                end
                bsrc_pkg::OP_SHOW_TOP: begin
                    if (nonempty) begin kind = bsrc_pkg::PK_STACK; pval = top; end
                end
                bsrc_pkg::OP_SHOW_REG: begin
                    if (a_reg) begin
                        kind = bsrc_pkg::PK_REG; preg = a[2:0]; pval = ra;
                    end
                end
                bsrc_pkg::OP_CMP:  flags_we = 1'b1;
                bsrc_pkg::OP_JEQ:  if (r_eq)  next = {2'b0, a};
                bsrc_pkg::OP_JNE:  if (!r_eq) next = {2'b0, a};
                bsrc_pkg::OP_JGT:  if (r_gt)  next = {2'b0, a};
                bsrc_pkg::OP_JLT:  if (r_lt)  next = {2'b0, a};
                bsrc_pkg::OP_MEM_PUSH: begin
                    push_do = a_mem; push_wd = ma;
                end
                bsrc_pkg::OP_POP_MEM: begin
                    pop_do = nonempty && a_mem; mem_we = pop_do; mem_wd = top;
                end
                bsrc_pkg::OP_MEM_TO_REG: begin
                    reg_we = a_reg && b_mem; reg_wd = mb;
                end
                bsrc_pkg::OP_REG_TO_MEM: begin
                    mem_we = b_reg && a_mem; mem_wd = rb;
                end
                bsrc_pkg::OP_DECR:     dec_do = 1'b1;
                bsrc_pkg::OP_SHOW_CNT: begin kind = bsrc_pkg::PK_CNT; pval = r_lc; end
                bsrc_pkg::OP_STOP:     cease = 1'b1;
                default: st = bsrc_pkg::ST_UNKNOWN;
            endcase
        end
        if (push_do && full) begin
            push_do = 1'b0; st = bsrc_pkg::ST_OVERFLOW;
        end
        if (cease) next = {1'b0, i_prog_len};
        halt_now = r_halt || (r_pc >= i_prog_len);
    end

    // Data memory. A write by the executing instruction is forwarded to the
    // instruction whose operands are read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (mem_wr) r_mem[mem_wa] <= mem_wd;
        if (q_take) begin
            r_ma_raw <= r_mem[qa];
            r_mb_raw <= r_mem[qb];
            r_ma_ok  <= r_mem_vld[qa];
            r_mb_ok  <= r_mem_vld[qb];
            r_ma_fwd <= mem_wr && (mem_wa == qa);
            r_mb_fwd <= mem_wr && (mem_wa == qb);
            r_fwd_wd <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_take) r_s_instr <= i_q_instr;
        if (fire) begin
            o_next_pc <= halt_now ? r_pc : next[8:0];
            o_print_kind  <= halt_now ? bsrc_pkg::PK_NONE : kind;
            o_print_reg   <= halt_now ? 3'd0 : preg;
            o_print_value <= halt_now ? 32'sd0 : $signed(pval);
            o_status      <= halt_now ? bsrc_pkg::ST_OK : st;
            o_halted <= halt_now || cease || (next >= {1'b0, i_prog_len});
        end
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= '0;
            r_mem_vld <= '0; r_sp <= '0; r_lc <= '0;
            r_eq <= 1'b0; r_gt <= 1'b0; r_lt <= 1'b0;
            r_pc <= '0; r_halt <= 1'b0; o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (q_take) r_s_valid <= 1'b1;
            else if (fire) r_s_valid <= 1'b0;
            if (fire) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (fire) begin
                if (halt_now) begin
                    r_halt <= 1'b1;
                end else begin
                    if (reg_we) r_regs[reg_wa] <= reg_wd;
                    if (push_do) r_stack[SW'(r_sp)] <= push_wd;
                    if (mem_we) r_mem_vld[mem_wa] <= 1'b1;
                    if (push_do) r_sp <= r_sp + 1'b1;
                    if (pop_do)  r_sp <= r_sp - 1'b1;
                    if (dec_do)  r_lc <= r_lc - 32'd1;
                    if (flags_we) begin
                        r_eq <= cx == cy;
                        r_gt <= $signed(cx) > $signed(cy);
                        r_lt <= $signed(cx) < $signed(cy);
                    end
                    r_pc <= next[8:0];
                    if (cease || next >= {1'b0, i_prog_len}) r_halt <= 1'b1;
                end
            end
        end
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= STACK_DEPTH) else $error("stack pointer out of range");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_eq, r_gt, r_lt}) <= 1) else $error("flags not exclusive");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt mark cleared");
    a_halted_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_halt) |=> (o_halted && o_status == bsrc_pkg::ST_OK))
        else $error("halted result wrong");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Runs random bytecode programs through bytecode_stack_register_core. Each
// instruction is executed by a local machine model as it is queued, and each
// result from the core is compared field by field against the model's answer.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [7:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_tb_instr;

    typedef struct {
        logic [8:0]  next_pc;
        logic        halted;
        logic [1:0]  print_kind;
        logic [2:0]  print_reg;
        logic [31:0] print_value;
        logic [1:0]  status;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_op = '0, in_a = '0, in_b = '0, in_c = '0;
    logic        out_ready = 1'b0;
    logic        o_cfg_ready, o_ready, o_valid, o_halted;
    logic [8:0]  o_next_pc;
    logic [1:0]  o_print_kind, o_status;
    logic [2:0]  o_print_reg;
    logic signed [31:0] o_print_value;

    bytecode_stack_register_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(o_ready),
        .i_opcode(in_op), .i_operand_a(in_a), .i_operand_b(in_b), .i_operand_c(in_c),
        .o_valid(o_valid), .i_ready(out_ready),
        .o_next_pc(o_next_pc), .o_halted(o_halted), .o_print_kind(o_print_kind),
        .o_print_reg(o_print_reg), .o_print_value(o_print_value), .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_tb_instr instr_q[$];
    t_outcome  result_q[$];
    int       errors = 0;
    int       cycle = 0;
    int       hold_cycles = 0;

    // Machine model state.
    logic [31:0] m_reg[8];
    logic [31:0] m_mem[256];
    logic [31:0] m_stk[16];
    int          m_sp;
    logic [31:0] m_cnt;
    logic        m_eq, m_gt, m_lt;
    logic [8:0]  m_pc;
    logic        m_halt;
    logic [8:0]  m_len;

    function automatic logic [31:0] cmp_value(logic [7:0] sel);
        if (sel == bsrc_pkg::COUNTER_SEL) return m_cnt;
        if (sel < 8) return m_reg[sel[2:0]];
        return 32'd0;
    endfunction

    function automatic logic push_word(logic [31:0] v);
        if (m_sp >= 16) return 1'b0;
        m_stk[m_sp] = v;
        m_sp++;
        return 1'b1;
    endfunction

    function automatic t_outcome execute(t_tb_instr t);
        t_outcome r;
        logic [9:0] nxt;
        logic cease;
        logic signed [31:0] x, y;
        r = '{default: '0};
        nxt = {1'b0, m_pc} + 10'd1;
        cease = 1'b0;
        if (m_halt || m_pc >= m_len) begin
            m_halt = 1'b1;
            r.next_pc = m_pc;
            r.halted = 1'b1;
            return r;
        end
        r.status = bsrc_pkg::ST_OK;
        case (t.op)
            bsrc_pkg::OP_PUSH:
                if (!push_word({24'd0, t.a})) r.status = bsrc_pkg::ST_OVERFLOW;
            bsrc_pkg::OP_MOV: if (t.a < 8) m_reg[t.a[2:0]] = {24'd0, t.b};
            bsrc_pkg::OP_ADDR: if (t.a < 8 && t.b < 8 && t.c < 8)
                m_reg[t.a[2:0]] = m_reg[t.b[2:0]] + m_reg[t.c[2:0]];
            bsrc_pkg::OP_REG_PUSH:
                if (t.a < 8 && !push_word(m_reg[t.a[2:0]]))
                    r.status = bsrc_pkg::ST_OVERFLOW;
            bsrc_pkg::OP_POP_REG: if (m_sp > 0 && t.a < 8) begin
                m_sp--;
                m_reg[t.a[2:0]] = m_stk[m_sp];
            end
            bsrc_pkg::OP_SHOW_TOP: if (m_sp > 0) begin
                r.print_kind = bsrc_pkg::PK_STACK;
                r.print_value = m_stk[m_sp-1];
            end
            bsrc_pkg::OP_SHOW_REG: if (t.a < 8) begin
                r.print_kind = bsrc_pkg::PK_REG;
                r.print_reg = t.a[2:0];
                r.print_value = m_reg[t.a[2:0]];
            end
            bsrc_pkg::OP_CMP: begin
                x = cmp_value(t.a);
                y = cmp_value(t.b);
                m_eq = (x == y);
                m_gt = (x > y);
                m_lt = (x < y);
            end
            bsrc_pkg::OP_JEQ: if (m_eq) nxt = {2'b0, t.a};
            bsrc_pkg::OP_JNE: if (!m_eq) nxt = {2'b0, t.a};
            bsrc_pkg::OP_JGT: if (m_gt) nxt = {2'b0, t.a};
            bsrc_pkg::OP_JLT: if (m_lt) nxt = {2'b0, t.a};
            bsrc_pkg::OP_MEM_PUSH:
                if (!push_word(m_mem[t.a])) r.status = bsrc_pkg::ST_OVERFLOW;
            bsrc_pkg::OP_POP_MEM: if (m_sp > 0) begin
                m_sp--;
                m_mem[t.a] = m_stk[m_sp];
            end
            bsrc_pkg::OP_MEM_TO_REG: if (t.a < 8) m_reg[t.a[2:0]] = m_mem[t.b];
            bsrc_pkg::OP_REG_TO_MEM: if (t.b < 8) m_mem[t.a] = m_reg[t.b[2:0]];
            bsrc_pkg::OP_DECR: m_cnt = m_cnt - 32'd1;
            bsrc_pkg::OP_SHOW_CNT: begin
                r.print_kind = bsrc_pkg::PK_CNT;
                r.print_value = m_cnt;
            end
            bsrc_pkg::OP_STOP: cease = 1'b1;
            default: r.status = bsrc_pkg::ST_UNKNOWN;
        endcase
        if (cease) nxt = {1'b0, m_len};
        if (cease || nxt >= {1'b0, m_len}) m_halt = 1'b1;
        m_pc = nxt[8:0];
        r.next_pc = m_pc;
        r.halted = m_halt;
        return r;
    endfunction

    task automatic queue_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b,
                               logic [7:0] c);
        t_tb_instr t;
        t = '{op, a, b, c};
        result_q.push_back(execute(t));
        instr_q.push_back(t);
    endtask

    function automatic logic [7:0] rand_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return bsrc_pkg::COUNTER_SEL;
        if (r < 50) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] rand_opcode();
        logic [7:0] ops[19];
        ops = '{bsrc_pkg::OP_PUSH, bsrc_pkg::OP_MOV, bsrc_pkg::OP_ADDR,
                bsrc_pkg::OP_REG_PUSH, bsrc_pkg::OP_POP_REG, bsrc_pkg::OP_SHOW_TOP,
                bsrc_pkg::OP_SHOW_REG, bsrc_pkg::OP_CMP, bsrc_pkg::OP_JEQ,
                bsrc_pkg::OP_JNE, bsrc_pkg::OP_JGT, bsrc_pkg::OP_JLT,
                bsrc_pkg::OP_MEM_PUSH, bsrc_pkg::OP_POP_MEM, bsrc_pkg::OP_MEM_TO_REG,
                bsrc_pkg::OP_REG_TO_MEM, bsrc_pkg::OP_DECR, bsrc_pkg::OP_SHOW_CNT,
                bsrc_pkg::OP_PUSH};
        if ($urandom_range(0, 99) < 4) return 8'($urandom_range(0, 255));
        return ops[$urandom_range(0, 18)];
    endfunction

    // Random instructions; when keep_alive is set the program is steered back
    // with an equal compare and a taken jump before it runs off the end.
    task automatic queue_random(int count, bit keep_alive);
        logic [7:0] op;
        repeat (count) begin
            if (keep_alive && m_pc >= 230) begin
                queue_instr(bsrc_pkg::OP_CMP, 8'd0, 8'd0, 8'($urandom));
                queue_instr(bsrc_pkg::OP_JEQ, 8'($urandom_range(0, 150)),
                            8'($urandom), 8'($urandom));
            end
            op = rand_opcode();
            if (op == bsrc_pkg::OP_STOP) op = bsrc_pkg::OP_DECR;
            queue_instr(op, rand_operand(), rand_operand(), rand_operand());
        end
    endtask

    task automatic write_length(logic [8:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        m_len = v;
    endtask

    task automatic drain();
        while (instr_q.size() > 0 || result_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    function automatic bit idle_now();
        if (cycle > 1000 && cycle < 1600) return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    always @(posedge i_clk) cycle <= cycle + 1;

    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // Instruction driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && !o_ready)) begin
            if (in_valid && o_ready) void'(instr_q.pop_front());
            if (instr_q.size() > 0 && !idle_now()) begin
                in_valid <= 1'b1;
                in_op <= instr_q[0].op;
                in_a <= instr_q[0].a;
                in_b <= instr_q[0].b;
                in_c <= instr_q[0].c;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected transfer", {23'd0, o_next_pc}, 32'd0);
                end else begin
                    e = result_q.pop_front();
                    if (o_next_pc !== e.next_pc)
                        report_mismatch("next_pc", {23'd0, o_next_pc}, {23'd0, e.next_pc});
                    if (o_halted !== e.halted)
                        report_mismatch("halted", {31'd0, o_halted}, {31'd0, e.halted});
                    if (o_print_kind !== e.print_kind)
                        report_mismatch("print_kind", {30'd0, o_print_kind},
                                        {30'd0, e.print_kind});
                    if (o_print_reg !== e.print_reg)
                        report_mismatch("print_reg", {29'd0, o_print_reg}, {29'd0, e.print_reg});
                    if (o_print_value !== e.print_value)
                        report_mismatch("print_value", o_print_value, e.print_value);
                    if (o_status !== e.status)
                        report_mismatch("status", {30'd0, o_status}, {30'd0, e.status});
                end
            end
            out_ready <= (hold_cycles == 0) && !idle_now();
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        foreach (m_reg[i]) m_reg[i] = '0;
        foreach (m_mem[i]) m_mem[i] = '0;
        foreach (m_stk[i]) m_stk[i] = '0;
        m_sp = 0; m_cnt = '0; m_eq = 0; m_gt = 0; m_lt = 0;
        m_pc = '0; m_halt = 0; m_len = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        write_length(9'd256);
        // Directed: empty stack, bad registers, counter compare, all jumps.
        queue_instr(bsrc_pkg::OP_SHOW_TOP, 8'd0, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_POP_REG, 8'd1, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_POP_MEM, 8'd3, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_MOV, 8'd1, 8'hFF, 8'd0);
        queue_instr(bsrc_pkg::OP_MOV, 8'd9, 8'd5, 8'd0);
        queue_instr(bsrc_pkg::OP_ADDR, 8'd2, 8'd1, 8'd1);
        queue_instr(bsrc_pkg::OP_ADDR, 8'd2, 8'd1, 8'hFF);
        queue_instr(bsrc_pkg::OP_DECR, 8'd0, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_SHOW_CNT, 8'd0, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_CMP, bsrc_pkg::COUNTER_SEL, 8'd1, 8'd0);
        queue_instr(bsrc_pkg::OP_JLT, 8'd40, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_CMP, 8'd20, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_JEQ, 8'd60, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_JNE, 8'd0, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_JGT, 8'd0, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_REG_PUSH, 8'd2, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_SHOW_TOP, 8'd0, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_REG_TO_MEM, 8'd255, 8'd2, 8'd0);
        queue_instr(bsrc_pkg::OP_MEM_PUSH, 8'd255, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_POP_MEM, 8'd7, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_MEM_TO_REG, 8'd7, 8'd7, 8'd0);
        queue_instr(bsrc_pkg::OP_SHOW_REG, 8'd7, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_SHOW_REG, 8'd8, 8'd0, 8'd0);
        queue_instr(bsrc_pkg::OP_RESERVED, 8'hFF, 8'hFF, 8'hFF);
        queue_instr(8'hFF, 8'd0, 8'd0, 8'd0);
        queue_instr(8'h00, 8'd0, 8'd0, 8'd0);

        queue_random(800, 1'b1);
        // Fill the stack past its depth so that pushes are dropped.
        repeat (18) queue_instr(bsrc_pkg::OP_PUSH, 8'($urandom), 8'd0, 8'd0);
        wait (instr_q.size() < 400);
        hold_cycles = 80;
        drain();
        queue_random(880, 1'b1);
        drain();

        // Shorter program: run off its end, or stop early.
        write_length((m_pc + 30 > 256) ? 9'd256 : 9'(m_pc + 30));
        queue_random(40, 1'b0);
        queue_instr(bsrc_pkg::OP_STOP, 8'd0, 8'd0, 8'd0);
        queue_random(5, 1'b0);
        drain();

        write_length(9'd0);
        queue_random(5, 1'b0);
        drain();

        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/bsrc_pkg.sv
rtl/bsrc_front.sv
rtl/bsrc_back.sv
rtl/bytecode_stack_register_core.sv
tb/tb_top.sv
